// ----- hdl/pqz_pkg.sv -----
`default_nettype none
package pqz_pkg;

  localparam int PALETTE_SIZE_DEF = 256;
  localparam int WEIGHT_FRAC_DEF  = 16;
  localparam int IDX_W            = 8;
  localparam int CH_W             = 8;
  localparam int METHOD_W         = 3;

  localparam logic [METHOD_W-1:0] METHOD_DIVIDE        = 3'd0;
  localparam logic [METHOD_W-1:0] METHOD_RGB           = 3'd1;
  localparam logic [METHOD_W-1:0] METHOD_RGB_LUMA      = 3'd2;
  localparam logic [METHOD_W-1:0] METHOD_WEIGHTED      = 3'd3;
  localparam logic [METHOD_W-1:0] METHOD_WEIGHTED_LUMA = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam longint W_RED_NUM = 2126;
  localparam longint W_GRN_NUM = 7152;
  localparam longint W_BLU_NUM = 722;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  function automatic longint weight(input longint num, input int frac);
    weight = ((num << frac) + 64'd5000) / 64'd10000;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pqz_if.sv -----
`default_nettype none
interface pqz_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, kind, entry_index, red, green, blue, input ready);
  modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface pqz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  modport source (output valid, color_index, input ready);
  modport sink   (input valid, color_index, output ready);
endinterface

interface pqz_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] color_method;
  modport source (output valid, color_method, input ready);
  modport sink   (input valid, color_method, output ready);
endinterface
`default_nettype wire

// ----- hdl/pqz_cell.sv -----
`default_nettype none
module pqz_cell #(
  parameter int WFB      = pqz_pkg::WEIGHT_FRAC_DEF,
  parameter int CELL_IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic [pqz_pkg::METHOD_W-1:0]     method,
  input  wire pqz_pkg::ctl_t                    ctl_i,
  input  wire logic [7:0]                       red_i,
  input  wire logic [7:0]                       green_i,
  input  wire logic [7:0]                       blue_i,
  input  wire logic [WFB+7:0]                   wr_i,
  input  wire logic [WFB+7:0]                   wg_i,
  input  wire logic [WFB+7:0]                   wb_i,
  input  wire logic [WFB+8:0]                   luma_i,
  input  wire logic [2*WFB+19:0]                cost_i,
  input  wire logic [7:0]                       best_i,
  output pqz_pkg::ctl_t                         ctl_o,
  output logic [7:0]                            red_o,
  output logic [7:0]                            green_o,
  output logic [7:0]                            blue_o,
  output logic [WFB+7:0]                        wr_o,
  output logic [WFB+7:0]                        wg_o,
  output logic [WFB+7:0]                        wb_o,
  output logic [WFB+8:0]                        luma_o,
  output logic [2*WFB+19:0]                     cost_o,
  output logic [7:0]                            best_o
);
  localparam int WP = WFB + 8;
  localparam int LW = WFB + 9;
  localparam int DW = WFB + 10;
  localparam int CW = 2 * WFB + 20;
  localparam logic [7:0] MY_IDX = 8'(CELL_IDX);

  logic [7:0]    er_r, eg_r, eb_r;
  logic [WP-1:0] ewr_r, ewg_r, ewb_r;
  logic [LW-1:0] el_r;

  pqz_pkg::ctl_t ctl_r;
  logic [7:0]    red_r, green_r, blue_r;
  logic [WP-1:0] wr_r, wg_r, wb_r;
  logic [LW-1:0] luma_r;
  logic [CW-1:0] cost_r;
  logic [7:0]    best_r;

  logic signed [8:0]    dr, dg, db;
  logic signed [17:0]   sr, sg, sb;
  logic [CW-1:0]        plain;
  logic signed [DW-1:0] wdr, wdg, wdb, ld;
  logic signed [CW-1:0] qr, qg, qb, ql;
  logic [CW-1:0]        weighted;
  logic [CW-1:0]        cost;
  logic                 take;
  logic                 load_hit;

  always_comb begin
    dr = $signed({1'b0, red_i})   - $signed({1'b0, er_r});
    dg = $signed({1'b0, green_i}) - $signed({1'b0, eg_r});
    db = $signed({1'b0, blue_i})  - $signed({1'b0, eb_r});
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    plain = CW'($unsigned(sr)) + CW'($unsigned(sg)) + CW'($unsigned(sb));
    wdr = $signed({2'b00, wr_i}) - $signed({2'b00, ewr_r});
    wdg = $signed({2'b00, wg_i}) - $signed({2'b00, ewg_r});
    wdb = $signed({2'b00, wb_i}) - $signed({2'b00, ewb_r});
    ld  = $signed({1'b0, luma_i}) - $signed({1'b0, el_r});
    qr = wdr * wdr;
    qg = wdg * wdg;
    qb = wdb * wdb;
    ql = ld * ld;
    weighted = $unsigned(qr) + $unsigned(qg) + $unsigned(qb);
    case (method)
      pqz_pkg::METHOD_RGB:      cost = plain;
      pqz_pkg::METHOD_RGB_LUMA: cost = (plain << (2 * WFB)) + $unsigned(ql);
      pqz_pkg::METHOD_WEIGHTED: cost = weighted;
      default:                  cost = weighted + $unsigned(ql);
    endcase
    take = (CELL_IDX == 0) || (cost < cost_i);
    load_hit = ctl_i.valid && (ctl_i.kind == pqz_pkg::KIND_LOAD) && (ctl_i.idx == MY_IDX);
  end

  always_ff @(posedge clk) begin
    if (en && load_hit) begin
      er_r  <= red_i;
      eg_r  <= green_i;
      eb_r  <= blue_i;
      ewr_r <= wr_i;
      ewg_r <= wg_i;
      ewb_r <= wb_i;
      el_r  <= luma_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_i;
      green_r <= green_i;
      blue_r  <= blue_i;
      wr_r    <= wr_i;
      wg_r    <= wg_i;
      wb_r    <= wb_i;
      luma_r  <= luma_i;
      cost_r  <= take ? cost : cost_i;
      best_r  <= take ? MY_IDX : best_i;
    end
  end

  assign ctl_o   = ctl_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;
  assign wr_o    = wr_r;
  assign wg_o    = wg_r;
  assign wb_o    = wb_r;
  assign luma_o  = luma_r;
  assign cost_o  = cost_r;
  assign best_o  = best_r;
endmodule
`default_nettype wire

// ----- hdl/palette_nearest_color_quantizer.sv -----
// Nearest palette color quantizer.
// in_ch carries requests: kind 0 loads palette slot entry_index with red,
// green, blue; kind 1 converts a pixel. out_ch returns one color_index per
// pixel request, none per load. cfg_ch writes color_method (0 divide,
// 1 rgb, 2 rgb+luma, 3 weighted rgb, 4 weighted rgb+luma); write it only
// while no request is in flight.
// Every request walks a row of min(PALETTE_SIZE, 256) palette cells, one
// cell per cycle; each cell holds one entry and keeps the running best
// match. Loads write their cell as they pass, so order is kept.
// Throughput: one request per cycle.
// Load all searched slots before the first distance-method pixel.
// Reset clears the pipeline valids and sets color_method to 0; palette
// contents are undefined until loaded.
// A stalled out_ch freezes the whole row and drops in_ch.ready.
`default_nettype none
module palette_nearest_color_quantizer #(
  parameter int PALETTE_SIZE         = pqz_pkg::PALETTE_SIZE_DEF,
  parameter int WEIGHT_FRACTION_BITS = pqz_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pqz_in_if.sink     in_ch,
  pqz_out_if.source  out_ch,
  pqz_cfg_if.sink    cfg_ch
);
  localparam int WFB = WEIGHT_FRACTION_BITS;
  localparam int NC  = (PALETTE_SIZE < 256) ? PALETTE_SIZE : 256;
  localparam int WP  = WFB + 8;
  localparam int LW  = WFB + 9;
  localparam int CW  = 2 * WFB + 20;
  localparam logic [WFB-1:0] W_RED = WFB'(pqz_pkg::weight(pqz_pkg::W_RED_NUM, WFB));
  localparam logic [WFB-1:0] W_GRN = WFB'(pqz_pkg::weight(pqz_pkg::W_GRN_NUM, WFB));
  localparam logic [WFB-1:0] W_BLU = WFB'(pqz_pkg::weight(pqz_pkg::W_BLU_NUM, WFB));

  logic [pqz_pkg::METHOD_W-1:0] method_r;
  logic                         en;
  logic                         out_valid_r;
  logic [7:0]                   color_r;

  pqz_pkg::ctl_t ch_ctl   [NC+1];
  logic [7:0]    ch_red   [NC+1];
  logic [7:0]    ch_green [NC+1];
  logic [7:0]    ch_blue  [NC+1];
  logic [WP-1:0] ch_wr    [NC+1];
  logic [WP-1:0] ch_wg    [NC+1];
  logic [WP-1:0] ch_wb    [NC+1];
  logic [LW-1:0] ch_luma  [NC+1];
  logic [CW-1:0] ch_cost  [NC+1];
  logic [7:0]    ch_best  [NC+1];

  pqz_pkg::ctl_t fa_ctl_r;
  logic [7:0]    fa_red_r, fa_green_r, fa_blue_r;
  logic [WP-1:0] fa_wr_r, fa_wg_r, fa_wb_r;
  logic [LW-1:0] fa_luma_r;
  logic [WP-1:0] wr_nxt, wg_nxt, wb_nxt;
  logic [LW-1:0] luma_nxt;
  logic [7:0]    div_idx;
  pqz_pkg::ctl_t tail;

  assign en           = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= pqz_pkg::METHOD_DIVIDE;
    end else if (cfg_ch.valid) begin
      method_r <= cfg_ch.color_method;
    end
  end

  always_comb begin
    wr_nxt   = WP'(in_ch.red)   * WP'(W_RED);
    wg_nxt   = WP'(in_ch.green) * WP'(W_GRN);
    wb_nxt   = WP'(in_ch.blue)  * WP'(W_BLU);
    luma_nxt = LW'(wr_nxt) + LW'(wg_nxt) + LW'(wb_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_ctl_r <= '0;
    end else if (en) begin
      fa_ctl_r.valid <= in_ch.valid;
      fa_ctl_r.kind  <= in_ch.kind;
      fa_ctl_r.idx   <= in_ch.entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_red_r   <= in_ch.red;
      fa_green_r <= in_ch.green;
      fa_blue_r  <= in_ch.blue;
      fa_wr_r    <= wr_nxt;
      fa_wg_r    <= wg_nxt;
      fa_wb_r    <= wb_nxt;
      fa_luma_r  <= luma_nxt;
    end
  end

  assign ch_ctl[0]   = fa_ctl_r;
  assign ch_red[0]   = fa_red_r;
  assign ch_green[0] = fa_green_r;
  assign ch_blue[0]  = fa_blue_r;
  assign ch_wr[0]    = fa_wr_r;
  assign ch_wg[0]    = fa_wg_r;
  assign ch_wb[0]    = fa_wb_r;
  assign ch_luma[0]  = fa_luma_r;
  assign ch_cost[0]  = '0;
  assign ch_best[0]  = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    pqz_cell #(
      .WFB      (WFB),
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .method  (method_r),
      .ctl_i   (ch_ctl[k]),
      .red_i   (ch_red[k]),
      .green_i (ch_green[k]),
      .blue_i  (ch_blue[k]),
      .wr_i    (ch_wr[k]),
      .wg_i    (ch_wg[k]),
      .wb_i    (ch_wb[k]),
      .luma_i  (ch_luma[k]),
      .cost_i  (ch_cost[k]),
      .best_i  (ch_best[k]),
      .ctl_o   (ch_ctl[k+1]),
      .red_o   (ch_red[k+1]),
      .green_o (ch_green[k+1]),
      .blue_o  (ch_blue[k+1]),
      .wr_o    (ch_wr[k+1]),
      .wg_o    (ch_wg[k+1]),
      .wb_o    (ch_wb[k+1]),
      .luma_o  (ch_luma[k+1]),
      .cost_o  (ch_cost[k+1]),
      .best_o  (ch_best[k+1])
    );
  end

  assign tail    = ch_ctl[NC];
  assign div_idx = {ch_green[NC][7:5], ch_red[NC][7:5], ch_blue[NC][7:6]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tail.valid && (tail.kind == pqz_pkg::KIND_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_r <= (method_r == pqz_pkg::METHOD_DIVIDE) ? div_idx : ch_best[NC];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.color_index = color_r;
endmodule
`default_nettype wire

// ----- sim/palette_nearest_color_quantizer_tb.sv -----
module palette_nearest_color_quantizer_tb;

  localparam longint WQ_RED = ((longint'(2126) << 16) + 5000) / 10000;
  localparam longint WQ_GRN = ((longint'(7152) << 16) + 5000) / 10000;
  localparam longint WQ_BLU = ((longint'(722) << 16) + 5000) / 10000;
  localparam int ROW_DRAIN = 270;
  localparam int STALL_LIMIT = 20000;
  localparam logic [pqz_pkg::METHOD_W-1:0] METHOD_SPARE = 3'd7;

  logic clk;
  logic rst_n;

  pqz_in_if  in_ch ();
  pqz_out_if out_ch ();
  pqz_cfg_if cfg_ch ();

  palette_nearest_color_quantizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  logic [23:0] shadow_palette [256];
  logic [pqz_pkg::METHOD_W-1:0] shadow_method;
  logic [7:0] pending_indexes [$];
  int in_idle_pct;
  int out_idle_pct;
  int mismatches;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] wide_square(longint v);
    logic [127:0] m;
    m = 128'((v < 0) ? -v : v);
    return m * m;
  endfunction

  function automatic logic [127:0] match_cost(logic [pqz_pkg::METHOD_W-1:0] m, longint dr,
                                              longint dg, longint db);
    longint luma;
    logic [127:0] acc;
    luma = WQ_RED * dr + WQ_GRN * dg + WQ_BLU * db;
    if (m == pqz_pkg::METHOD_RGB) begin
      acc = 128'(dr * dr + dg * dg + db * db);
    end else if (m == pqz_pkg::METHOD_RGB_LUMA) begin
      acc = (128'(dr * dr + dg * dg + db * db) << 32) + wide_square(luma);
    end else begin
      acc = wide_square(WQ_RED * dr) + wide_square(WQ_GRN * dg) + wide_square(WQ_BLU * db);
      if (m != pqz_pkg::METHOD_WEIGHTED) acc = acc + wide_square(luma);
    end
    return acc;
  endfunction

  function automatic logic [7:0] nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [127:0] best_cost;
    logic [127:0] c;
    logic [7:0] best;
    if (shadow_method == pqz_pkg::METHOD_DIVIDE) return {g[7:5], r[7:5], b[7:6]};
    best = '0;
    for (int k = 0; k < 256; k++) begin
      c = match_cost(shadow_method, longint'(r) - longint'(shadow_palette[k][23:16]),
                     longint'(g) - longint'(shadow_palette[k][15:8]),
                     longint'(b) - longint'(shadow_palette[k][7:0]));
      if (k == 0 || c < best_cost) begin
        best_cost = c;
        best = k[7:0];
      end
    end
    return best;
  endfunction

  task automatic send_request(logic kind, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.entry_index <= idx;
    in_ch.red <= r;
    in_ch.green <= g;
    in_ch.blue <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == pqz_pkg::KIND_LOAD) shadow_palette[idx] = {r, g, b};
    else pending_indexes.push_back(nearest_color(r, g, b));
  endtask

  task automatic drain_row();
    in_ch.valid <= 1'b0;
    while (pending_indexes.size() != 0) @(posedge clk);
    repeat (ROW_DRAIN) @(posedge clk);
  endtask

  task automatic set_method(logic [pqz_pkg::METHOD_W-1:0] m);
    drain_row();
    cfg_ch.valid <= 1'b1;
    cfg_ch.color_method <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_method = m;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_request(pqz_pkg::KIND_PIXEL, 8'($urandom), r, g, b);
  endtask

  task automatic test_divide();
    set_method(pqz_pkg::METHOD_DIVIDE);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'h1f, 8'h20, 8'h3f);
    send_pixel(8'h20, 8'h1f, 8'h40);
    repeat (25) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_load_palette();
    send_request(pqz_pkg::KIND_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(pqz_pkg::KIND_LOAD, 8'd255, 8'hff, 8'hff, 8'hff);
    for (int k = 1; k < 255; k++) begin
      send_request(pqz_pkg::KIND_LOAD, k[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
    end
    // duplicate colors: lowest slot must win the tie
    send_request(pqz_pkg::KIND_LOAD, 8'd10, 8'h80, 8'h40, 8'hc0);
    send_request(pqz_pkg::KIND_LOAD, 8'd20, 8'h80, 8'h40, 8'hc0);
  endtask

  task automatic test_method(logic [pqz_pkg::METHOD_W-1:0] m);
    logic [7:0] slot;
    set_method(m);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h40, 8'hc0);
    send_pixel(8'hff, 8'h00, 8'hff);
    repeat (85) begin
      if ($urandom_range(99) < 15) begin
        send_request(pqz_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
      end else if ($urandom_range(1) == 0) begin
        slot = 8'($urandom);
        send_pixel(shadow_palette[slot][23:16] ^ 8'($urandom_range(3)),
                   shadow_palette[slot][15:8], shadow_palette[slot][7:0]);
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_indexes.size() == 0) begin
        $error("color_index: expected none, actual %0d", out_ch.color_index);
        mismatches++;
      end else begin
        if (out_ch.color_index !== pending_indexes[0]) begin
          $error("color_index: expected %0d, actual %0d", pending_indexes[0],
                 out_ch.color_index);
          mismatches++;
        end
        void'(pending_indexes.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shadow_method = pqz_pkg::METHOD_DIVIDE;
    for (int k = 0; k < 256; k++) shadow_palette[k] = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.entry_index = '0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.color_method = '0;
    in_idle_pct = 19;
    out_idle_pct = 77;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_divide();
    test_load_palette();
    test_method(pqz_pkg::METHOD_RGB);
    test_method(pqz_pkg::METHOD_RGB_LUMA);
    in_idle_pct = 77;
    out_idle_pct = 19;
    test_method(pqz_pkg::METHOD_WEIGHTED);
    test_method(pqz_pkg::METHOD_WEIGHTED_LUMA);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_method(METHOD_SPARE);
    test_divide();

    drain_row();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
